// ===== rtl/hts_pkg.sv =====
`timescale 1ns / 1ps

package hts_pkg;

    // Full circle in tenths of a degree.
    localparam int unsigned HEADING_FULL_SCALE = 3600;

    localparam logic [9:0] SPEED_MAX = 10'd1000;

    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_APPROACH = 3'd1;
    localparam logic [2:0] PH_PAUSE1   = 3'd2;
    localparam logic [2:0] PH_SPIN     = 3'd3;
    localparam logic [2:0] PH_PAUSE2   = 3'd4;
    localparam logic [2:0] PH_DEPART   = 3'd5;

    localparam int unsigned ADDR_W = 5;

    localparam logic [2:0] REG_CRUISE_SPEED = 3'd0;
    localparam logic [2:0] REG_SPIN_SPEED   = 3'd1;
    localparam logic [2:0] REG_APPROACH_MS  = 3'd2;
    localparam logic [2:0] REG_PAUSE_MS     = 3'd3;
    localparam logic [2:0] REG_SETTLE_MS    = 3'd4;
    localparam logic [2:0] REG_DEPART_MS    = 3'd5;
    localparam logic [2:0] REG_TURN_ANGLE   = 3'd6;

    typedef struct packed {
        logic        start_turn;
        logic        turn_left;
        logic [11:0] heading;
    } in_item_t;

    typedef struct packed {
        logic       a_forward;
        logic       a_reverse;
        logic [9:0] a_level;
        logic       b_forward;
        logic       b_reverse;
        logic [9:0] b_level;
        logic       busy_res;
        logic       done_res;
    } out_item_t;

    typedef struct packed {
        logic [9:0]  cruise_speed;
        logic [9:0]  spin_speed;
        logic [15:0] approach_ms;
        logic [15:0] pause_ms;
        logic [15:0] settle_ms;
        logic [15:0] depart_ms;
        logic [11:0] turn_angle;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  phase;
        logic [15:0] phase_timer;
        logic [11:0] start_heading;
        logic [15:0] target_heading;
        logic        target_wrapped;
        logic        going_left;
    } seq_state_t;

endpackage

// ===== rtl/heading_turn_sequencer.sv =====
`timescale 1ns / 1ps

// Turn-in-place sequencer for a two-motor robot, fed one item per millisecond
// tick. Each input item carries a start request, a turn direction and the
// compass heading; each accepted item yields exactly one result item with the
// direction pins and PWM levels of both motors plus busy and done flags.
// A start while idle runs approach, pause, spin, pause and depart, each timed
// in ticks by the registers on the APB port; the spin ends once the settle
// time has passed and the heading has crossed the target.
// The result of an item is valid in the cycle after it is accepted. Throughput
// is one item per cycle while the receiver does not stall, set by the single
// result register, which is refilled in the same cycle it is taken.
// When the receiver stalls, the result register holds its item and in_stall
// rises, so no item is lost. Reset puts the sequencer in idle, empties the
// result register and loads the default register values. Registers should be
// written only while the sequencer is idle.
module heading_turn_sequencer (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  hts_pkg::in_item_t            in_data,
    output logic                         out_valid,
    input  logic                         out_stall,
    output hts_pkg::out_item_t           out_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [hts_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    hts_pkg::cfg_t       cfg_reg;
    hts_pkg::seq_state_t state_reg;
    hts_pkg::seq_state_t state_next;
    hts_pkg::out_item_t  out_reg;
    hts_pkg::out_item_t  out_next;
    logic                out_valid_reg;
    logic                accept;
    logic                cfg_write;
    logic [2:0]          reg_idx;

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[hts_pkg::ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    hts_step u_step (
        .state      (state_reg),
        .cfg        (cfg_reg),
        .item       (in_data),
        .state_next (state_next),
        .result     (out_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cruise_speed <= 10'd200;
            cfg_reg.spin_speed   <= 10'd100;
            cfg_reg.approach_ms  <= 16'd600;
            cfg_reg.pause_ms     <= 16'd500;
            cfg_reg.settle_ms    <= 16'd50;
            cfg_reg.depart_ms    <= 16'd500;
            cfg_reg.turn_angle   <= 12'd900;
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                hts_pkg::REG_CRUISE_SPEED: cfg_reg.cruise_speed <= pwdata[9:0];
                hts_pkg::REG_SPIN_SPEED:   cfg_reg.spin_speed   <= pwdata[9:0];
                hts_pkg::REG_APPROACH_MS:  cfg_reg.approach_ms  <= pwdata[15:0];
                hts_pkg::REG_PAUSE_MS:     cfg_reg.pause_ms     <= pwdata[15:0];
                hts_pkg::REG_SETTLE_MS:    cfg_reg.settle_ms    <= pwdata[15:0];
                hts_pkg::REG_DEPART_MS:    cfg_reg.depart_ms    <= pwdata[15:0];
                hts_pkg::REG_TURN_ANGLE:   cfg_reg.turn_angle   <= pwdata[11:0];
                default:                   cfg_reg              <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            hts_pkg::REG_CRUISE_SPEED: prdata = {22'd0, cfg_reg.cruise_speed};
            hts_pkg::REG_SPIN_SPEED:   prdata = {22'd0, cfg_reg.spin_speed};
            hts_pkg::REG_APPROACH_MS:  prdata = {16'd0, cfg_reg.approach_ms};
            hts_pkg::REG_PAUSE_MS:     prdata = {16'd0, cfg_reg.pause_ms};
            hts_pkg::REG_SETTLE_MS:    prdata = {16'd0, cfg_reg.settle_ms};
            hts_pkg::REG_DEPART_MS:    prdata = {16'd0, cfg_reg.depart_ms};
            hts_pkg::REG_TURN_ANGLE:   prdata = {20'd0, cfg_reg.turn_angle};
            default:                   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase          <= hts_pkg::PH_IDLE;
            state_reg.phase_timer    <= '0;
            state_reg.start_heading  <= '0;
            state_reg.target_heading <= '0;
            state_reg.target_wrapped <= 1'b0;
            state_reg.going_left     <= 1'b0;
            out_valid_reg            <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_reg <= out_next;
        end
    end

endmodule

// ===== rtl/hts_step.sv =====
`timescale 1ns / 1ps

module hts_step (
    input  hts_pkg::seq_state_t state,
    input  hts_pkg::cfg_t       cfg,
    input  hts_pkg::in_item_t   item,
    output hts_pkg::seq_state_t state_next,
    output hts_pkg::out_item_t  result
);

    localparam logic signed [17:0] FULL = 18'(hts_pkg::HEADING_FULL_SCALE);

    logic [2:0]         ph;
    logic [15:0]        tm;
    logic [11:0]        sh;
    logic [15:0]        th;
    logic               tw;
    logic               gl;
    logic               done;
    logic               spin_done;
    logic [15:0]        h16;
    logic signed [17:0] diff;
    logic [9:0]         cruise_lvl;
    logic [9:0]         spin_lvl;

    assign h16 = {4'd0, item.heading};
    assign cruise_lvl = (cfg.cruise_speed > hts_pkg::SPEED_MAX) ? hts_pkg::SPEED_MAX
                                                                 : cfg.cruise_speed;
    assign spin_lvl = (cfg.spin_speed > hts_pkg::SPEED_MAX) ? hts_pkg::SPEED_MAX
                                                             : cfg.spin_speed;

    always_comb
    begin
        ph   = state.phase;
        tm   = state.phase_timer;
        sh   = state.start_heading;
        th   = state.target_heading;
        tw   = state.target_wrapped;
        gl   = state.going_left;
        done = 1'b0;
        diff = '0;
        spin_done = 1'b0;

        if (ph == hts_pkg::PH_IDLE && item.start_turn)
        begin
            gl = item.turn_left;
            ph = hts_pkg::PH_APPROACH;
            tm = '0;
        end

        if (ph > hts_pkg::PH_DEPART)
        begin
            ph = hts_pkg::PH_IDLE;
            tm = '0;
        end

        // Phases only move forward, so the whole chain of handovers within
        // one item is a fixed sequence of checks.
        if (ph == hts_pkg::PH_APPROACH && tm >= cfg.approach_ms)
        begin
            ph = hts_pkg::PH_PAUSE1;
            tm = '0;
        end

        if (ph == hts_pkg::PH_PAUSE1 && tm >= cfg.pause_ms)
        begin
            sh = item.heading;
            tw = 1'b0;
            if (gl)
            begin
                diff = $signed({6'd0, item.heading}) - $signed({6'd0, cfg.turn_angle});
                if (diff < 0)
                begin
                    diff = diff + FULL;
                    tw   = 1'b1;
                end
            end
            else
            begin
                diff = $signed({6'd0, item.heading}) + $signed({6'd0, cfg.turn_angle});
                if (diff > FULL)
                begin
                    diff = diff - FULL;
                    tw   = 1'b1;
                end
            end
            if (diff < 0)
            begin
                diff = '0;
            end
            th = diff[15:0];
            ph = hts_pkg::PH_SPIN;
            tm = '0;
        end

        if (gl)
        begin
            if (tw)
            begin
                spin_done = (item.heading >= sh) && (h16 <= th);
            end
            else
            begin
                spin_done = (item.heading >= sh) || (h16 <= th);
            end
        end
        else
        begin
            if (tw)
            begin
                spin_done = (item.heading <= sh) && (h16 >= th);
            end
            else
            begin
                spin_done = (item.heading <= sh) || (h16 >= th);
            end
        end

        if (ph == hts_pkg::PH_SPIN && tm >= cfg.settle_ms && spin_done)
        begin
            ph = hts_pkg::PH_PAUSE2;
            tm = '0;
        end

        if (ph == hts_pkg::PH_PAUSE2 && tm >= cfg.pause_ms)
        begin
            ph = hts_pkg::PH_DEPART;
            tm = '0;
        end

        if (ph == hts_pkg::PH_DEPART && tm >= cfg.depart_ms)
        begin
            ph   = hts_pkg::PH_IDLE;
            tm   = '0;
            done = 1'b1;
        end

        result = '0;
        case (ph)
            hts_pkg::PH_APPROACH, hts_pkg::PH_DEPART:
            begin
                result.a_forward = (cruise_lvl != '0);
                result.a_level   = cruise_lvl;
                result.b_forward = (cruise_lvl != '0);
                result.b_level   = cruise_lvl;
            end
            hts_pkg::PH_SPIN:
            begin
                result.a_forward = !gl && (spin_lvl != '0);
                result.a_reverse = gl && (spin_lvl != '0);
                result.a_level   = spin_lvl;
                result.b_forward = gl && (spin_lvl != '0);
                result.b_reverse = !gl && (spin_lvl != '0);
                result.b_level   = spin_lvl;
            end
            default:
            begin
                result.a_level = '0;
            end
        endcase
        result.busy_res = (ph != hts_pkg::PH_IDLE);
        result.done_res = done;

        if (ph != hts_pkg::PH_IDLE && tm != 16'hFFFF)
        begin
            tm = tm + 16'd1;
        end

        state_next.phase          = ph;
        state_next.phase_timer    = tm;
        state_next.start_heading  = sh;
        state_next.target_heading = th;
        state_next.target_wrapped = tw;
        state_next.going_left     = gl;
    end

endmodule

// ===== rtl/hts_checker.sv =====
`timescale 1ns / 1ps

module hts_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input hts_pkg::out_item_t out_data
);

    // A stalled result stays put until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result item changed or vanished");

    // Every accepted item shows up as a result in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_valid)
        else $error("accepted item produced no result");

    // The input side only backs up when a result is waiting on the receiver.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a blocked result");

    // The done pulse comes with the sequencer back in idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.done_res |-> !out_data.busy_res)
        else $error("done reported while still busy");

    // A motor never drives both direction pins and never exceeds full duty.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.a_forward && out_data.a_reverse)
                      && !(out_data.b_forward && out_data.b_reverse)
                      && out_data.a_level <= hts_pkg::SPEED_MAX
                      && out_data.b_level <= hts_pkg::SPEED_MAX)
        else $error("illegal motor drive in result item");

endmodule

bind heading_turn_sequencer hts_checker u_hts_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
